// ===== hw/rtl/wtru_pkg.sv =====
// Shared types and constants for the word table RLE unpacker.
package wtru_pkg;

	localparam int TableEntries = 256;

	localparam logic [1:0] KIND_BITMAP = 2'd0;
	localparam logic [1:0] KIND_DELTA  = 2'd1;
	localparam logic [1:0] KIND_CODE   = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	localparam logic [1:0] REG_FIRST_BIAS  = 2'd0;
	localparam logic [1:0] REG_SECOND_BIAS = 2'd1;
	localparam logic [1:0] REG_WORD_OFFSET = 2'd2;
	localparam logic [1:0] REG_UNPACKED    = 2'd3;

	localparam logic [15:0] ENTRY_PAIR    = 16'h0000;
	localparam logic [15:0] ENTRY_REPEAT  = 16'h0001;
	localparam logic [15:0] ENTRY_LITERAL = 16'h8000;
	localparam logic [7:0]  CODE_FLIP     = 8'h80;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] payload;
	} item_t;

	typedef struct packed {
		logic [15:0] first_byte_bias;
		logic [15:0] second_byte_bias;
		logic [15:0] word_offset;
		logic [15:0] unpacked_bytes;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_BITMAP,
		ST_WALK,
		ST_FIRST,
		ST_SECOND,
		ST_CODE,
		ST_LOOK,
		ST_LOW,
		ST_COUNT,
		ST_LITHI,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/wtru_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wtru_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/wtru_front.sv =====
// Front end: accepts items, drops the unused kind, queues the rest for the back end.
module wtru_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  wtru_pkg::item_t in_item,
	output logic            item_valid,
	output wtru_pkg::item_t item,
	input  logic            item_take
);

	wtru_pkg::item_t buf_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            accept;
	logic            store;
	logic            take;

	assign full       = (count_q == 2'd2);
	assign accept     = push && !full;
	// drop kind 3 at the door, it never does anything
	assign store      = accept && (in_item.kind != wtru_pkg::KIND_NONE);
	assign item_valid = (count_q != 2'd0);
	assign item       = buf_q[rd_ptr_q];
	assign take       = item_take && item_valid;

	always_ff @(posedge clk) begin
		if (store) begin
			buf_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (store) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, store} - {1'b0, take};
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("front queue overflow");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		full && !take |=> count_q == 2'd2)
		else $error("full queue lost an item");

endmodule

// ===== hw/rtl/wtru_back.sv =====
// Back end: table build, code lookup, run clipping and the result register.
module wtru_back #(
	parameter int TABLE_ENTRIES = wtru_pkg::TableEntries
) (
	input  logic            clk,
	input  logic            arst_n,
	input  wtru_pkg::cfg_t  cfg,
	input  logic            item_valid,
	input  wtru_pkg::item_t item,
	output logic            item_take,
	output logic            empty,
	input  logic            pop,
	output logic [15:0]     word_value,
	output logic [8:0]      repeat_count,
	output logic            final_word
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int FW = IW + 1;
	localparam logic [FW-1:0] FILL_RESET = FW'(TABLE_ENTRIES);

	wtru_pkg::state_t state_q, state_d;
	logic [15:0]   shift_q, shift_d;
	logic [4:0]    bitpos_q, bitpos_d;
	logic [FW-1:0] fill_q, fill_d;
	logic [15:0]   sum_q, sum_d;
	logic [15:0]   pend_q, pend_d;
	logic [15:0]   last_q, last_d;
	logic [16:0]   bp_q, bp_d;
	logic          out_valid_q, out_valid_d;
	logic [15:0]   out_word_q, out_word_d;
	logic [8:0]    out_cnt_q, out_cnt_d;
	logic          out_fin_q, out_fin_d;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;

	logic [7:0]    b;
	logic [15:0]   sb;
	logic [15:0]   v_first;
	logic [15:0]   v_second;
	logic [15:0]   sum_new;
	logic [7:0]    code_idx;
	logic          is_code;
	logic          is_delta;
	logic          slot_free;
	logic          emit;
	logic [15:0]   emit_word;
	logic [8:0]    emit_cnt;
	logic [16:0]   remain;
	logic [15:0]   need;
	logic          fin;
	logic [8:0]    clip_cnt;

	assign b         = item.payload[7:0];
	assign sb        = {{8{b[7]}}, b};
	assign v_first   = sb - cfg.first_byte_bias;
	assign v_second  = {pend_q[7:0], b} - cfg.second_byte_bias;
	assign code_idx  = b ^ wtru_pkg::CODE_FLIP;
	assign is_code   = (item.kind == wtru_pkg::KIND_CODE);
	assign is_delta  = (item.kind == wtru_pkg::KIND_DELTA);
	assign slot_free = !out_valid_q || pop;

	// words still needed to reach the unpacked length, odd byte rounds up
	assign remain   = {1'b0, cfg.unpacked_bytes} - bp_q + 17'd1;
	always_comb begin
		need = 16'd1;
		if (bp_q < {1'b0, cfg.unpacked_bytes} && remain[16:1] != 16'd0) begin
			need = remain[16:1];
		end
	end
	assign fin      = ({7'd0, emit_cnt} >= need);
	assign clip_cnt = fin ? need[8:0] : emit_cnt;

	wtru_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES)) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// hold the looked-up address while a decode waits for the result register
	assign ram_raddr = (state_q == wtru_pkg::ST_LOOK) ?
		IW'(pend_q[7:0] ^ wtru_pkg::CODE_FLIP) : IW'(code_idx);

	always_comb begin
		state_d     = state_q;
		shift_d     = shift_q;
		bitpos_d    = bitpos_q;
		fill_d      = fill_q;
		sum_d       = sum_q;
		pend_d      = pend_q;
		item_take   = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = fill_q[IW-1:0];
		ram_wdata   = 16'd0;
		sum_new     = 16'd0;
		emit        = 1'b0;
		emit_word   = 16'd0;
		emit_cnt    = 9'd1;
		unique case (state_q)
			wtru_pkg::ST_BITMAP: begin
				item_take = 1'b1;
				if (item_valid && item.kind == wtru_pkg::KIND_BITMAP) begin
					shift_d  = item.payload;
					bitpos_d = 5'd16;
					state_d  = wtru_pkg::ST_WALK;
				end
			end
			wtru_pkg::ST_WALK: begin
				if (bitpos_q != 5'd0 && fill_q != '0) begin
					shift_d  = {shift_q[14:0], 1'b0};
					bitpos_d = bitpos_q - 5'd1;
					fill_d   = fill_q - FW'(1);
					if (shift_q[15]) begin
						state_d = wtru_pkg::ST_FIRST;
					end else begin
						ram_we    = 1'b1;
						ram_waddr = fill_d[IW-1:0];
					end
				end else begin
					state_d = (fill_q == '0) ? wtru_pkg::ST_CODE : wtru_pkg::ST_BITMAP;
				end
			end
			wtru_pkg::ST_FIRST: begin
				item_take = 1'b1;
				if (item_valid && is_delta) begin
					if (!v_first[15]) begin
						pend_d  = v_first;
						state_d = wtru_pkg::ST_SECOND;
					end else begin
						sum_new   = sum_q - v_first;
						sum_d     = sum_new;
						ram_we    = 1'b1;
						ram_wdata = sum_new;
						state_d   = wtru_pkg::ST_WALK;
					end
				end
			end
			wtru_pkg::ST_SECOND: begin
				item_take = 1'b1;
				if (item_valid && is_delta) begin
					sum_new   = sum_q - v_second;
					sum_d     = sum_new;
					ram_we    = 1'b1;
					ram_wdata = sum_new;
					state_d   = wtru_pkg::ST_WALK;
				end
			end
			wtru_pkg::ST_CODE: begin
				item_take = 1'b1;
				if (item_valid && is_code) begin
					pend_d  = {8'd0, b};
					state_d = wtru_pkg::ST_LOOK;
				end
			end
			wtru_pkg::ST_LOOK: begin
				priority if (ram_rdata == wtru_pkg::ENTRY_PAIR) begin
					state_d = wtru_pkg::ST_LOW;
				end else if (ram_rdata == wtru_pkg::ENTRY_REPEAT) begin
					state_d = wtru_pkg::ST_COUNT;
				end else if (ram_rdata == wtru_pkg::ENTRY_LITERAL) begin
					state_d = wtru_pkg::ST_LITHI;
				end else if (slot_free) begin
					emit      = 1'b1;
					emit_word = ram_rdata + cfg.word_offset;
				end
			end
			wtru_pkg::ST_LITHI: begin
				item_take = 1'b1;
				if (item_valid && is_code) begin
					pend_d  = {8'd0, b};
					state_d = wtru_pkg::ST_LOW;
				end
			end
			wtru_pkg::ST_LOW: begin
				// hold a code byte until the result register can take the word
				item_take = !is_code || slot_free;
				if (item_valid && is_code && slot_free) begin
					emit      = 1'b1;
					emit_word = {pend_q[7:0], b};
				end
			end
			wtru_pkg::ST_COUNT: begin
				item_take = !is_code || slot_free;
				if (item_valid && is_code && slot_free) begin
					emit      = 1'b1;
					emit_word = last_q;
					emit_cnt  = (b == 8'd0) ? 9'd256 : {1'b0, b};
				end
			end
			wtru_pkg::ST_DONE: begin
				item_take = 1'b1;
			end
			default: begin
				state_d = wtru_pkg::ST_DONE;
			end
		endcase
		if (emit) begin
			state_d = fin ? wtru_pkg::ST_DONE : wtru_pkg::ST_CODE;
		end
	end

	always_comb begin
		last_d      = last_q;
		bp_d        = bp_q;
		out_valid_d = out_valid_q && !pop;
		out_word_d  = out_word_q;
		out_cnt_d   = out_cnt_q;
		out_fin_d   = out_fin_q;
		if (emit) begin
			last_d      = emit_word;
			bp_d        = bp_q + {7'd0, clip_cnt, 1'b0};
			out_valid_d = 1'b1;
			out_word_d  = emit_word;
			out_cnt_d   = clip_cnt;
			out_fin_d   = fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wtru_pkg::ST_BITMAP;
			shift_q     <= '0;
			bitpos_q    <= '0;
			fill_q      <= FILL_RESET;
			sum_q       <= '0;
			pend_q      <= '0;
			last_q      <= '0;
			bp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			shift_q     <= shift_d;
			bitpos_q    <= bitpos_d;
			fill_q      <= fill_d;
			sum_q       <= sum_d;
			pend_q      <= pend_d;
			last_q      <= last_d;
			bp_q        <= bp_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		out_word_q <= out_word_d;
		out_cnt_q  <= out_cnt_d;
		out_fin_q  <= out_fin_d;
	end

	assign empty        = !out_valid_q;
	assign word_value   = out_word_q;
	assign repeat_count = out_cnt_q;
	assign final_word   = out_fin_q;

	a_done_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wtru_pkg::ST_DONE |=> state_q == wtru_pkg::ST_DONE)
		else $error("left done state without reset");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_RESET)
		else $error("fill index out of range");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(out_word_q) && $stable(out_cnt_q))
		else $error("waiting result changed");

	a_code_needs_full_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wtru_pkg::ST_LOOK |-> fill_q == '0)
		else $error("table read before build finished");

endmodule

// ===== hw/rtl/word_table_rle_unpacker.sv =====
// Word table RLE unpacker top level: configuration registers, front and back ends.
//
// Items arrive in backward stream order: bitmap words and delta bytes build a
// 256-entry word table, then code and data bytes unpack into words with a repeat
// count. A bitmap word is accepted and then walks its sixteen bits, one table
// entry written per cycle for clear bits; a set bit pauses the walk until its
// delta bytes have stored the entry. A code byte is taken while the table memory
// is read, and the entry is decoded from the registered read data; data and count
// bytes wait for the result register. A two-entry queue at the input keeps
// accepting while the back end walks, and a result register holds the oldest
// result until it is popped.
module word_table_rle_unpacker #(
	parameter int TABLE_ENTRIES = wtru_pkg::TableEntries
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [15:0] payload,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] word_value,
	output logic [8:0]  repeat_count,
	output logic        final_word
);

	wtru_pkg::cfg_t  cfg_q;
	wtru_pkg::item_t in_item;
	wtru_pkg::item_t item;
	logic            item_valid;
	logic            item_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wtru_pkg::REG_FIRST_BIAS:  cfg_q.first_byte_bias  <= cfg_data;
				wtru_pkg::REG_SECOND_BIAS: cfg_q.second_byte_bias <= cfg_data;
				wtru_pkg::REG_WORD_OFFSET: cfg_q.word_offset      <= cfg_data;
				wtru_pkg::REG_UNPACKED:    cfg_q.unpacked_bytes   <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign in_item.kind    = kind;
	assign in_item.payload = payload;

	wtru_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.item_valid(item_valid),
		.item      (item),
		.item_take (item_take)
	);

	wtru_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.item_valid  (item_valid),
		.item        (item),
		.item_take   (item_take),
		.empty       (empty),
		.pop         (pop),
		.word_value  (word_value),
		.repeat_count(repeat_count),
		.final_word  (final_word)
	);

endmodule

// ===== tb/word_table_rle_unpacker_test.sv =====
// Self-checking testbench for the word table RLE unpacker.
`timescale 1ns / 1ps

module word_table_rle_unpacker_test;

	typedef enum logic [2:0] {
		P_BITMAP, P_FIRST, P_SECOND, P_CODE, P_LOW, P_COUNT, P_LITHI, P_DONE
	} phase_t;

	typedef struct packed {
		logic [15:0] word_value;
		logic [8:0]  repeat_count;
		logic        final_word;
	} word_run_t;

	localparam int CycleLimit = 600000;
	localparam int SettleCycles = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = wtru_pkg::REG_FIRST_BIAS;
	logic [15:0] cfg_data = '0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  kind = wtru_pkg::KIND_NONE;
	logic [15:0] payload = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] word_value;
	logic [8:0]  repeat_count;
	logic        final_word;

	// predicted block state
	logic [15:0] words [wtru_pkg::TableEntries];
	logic [15:0] bit_shift, running_sum, held_byte, last_word;
	int          bits_left, fill_at, bytes_out;
	phase_t      phase;
	logic [15:0] first_bias, second_bias, word_offset, unpacked_bytes;

	word_run_t   expected_runs [$];
	int          errors = 0;
	int          items_sent = 0;
	int          cycles = 0;
	bit          quiet = 1'b0;
	int          pop_stall = 0;

	word_table_rle_unpacker dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .push, .full, .kind, .payload,
		.empty, .pop, .word_value, .repeat_count, .final_word
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Check each popped result against the oldest prediction.
	always @(posedge clk) begin
		word_run_t want;
		if (arst_n && pop && !empty) begin
			if (expected_runs.size() == 0) begin
				report("unexpected result word", word_value, 16'h0);
			end else begin
				want = expected_runs.pop_front();
				if (word_value !== want.word_value)
					report("word_value", word_value, want.word_value);
				if (repeat_count !== want.repeat_count)
					report("repeat_count", 16'(repeat_count), 16'(want.repeat_count));
				if (final_word !== want.final_word)
					report("final_word", 16'(final_word), 16'(want.final_word));
			end
		end
	end

	// Random pop stalls in bursts of random length.
	always @(negedge clk) begin
		if (quiet) begin
			pop <= 1'b1;
		end else if (pop_stall > 0) begin
			pop_stall <= pop_stall - 1;
			pop <= 1'b0;
		end else if ($urandom_range(5) == 0) begin
			pop_stall <= $urandom_range(3);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	function automatic void walk_bitmap();
		while (bits_left > 0 && fill_at > 0) begin
			logic bit_set;
			bit_set = bit_shift[15];
			bit_shift = bit_shift << 1;
			bits_left--;
			fill_at--;
			if (bit_set) begin
				phase = P_FIRST;
				return;
			end
			words[fill_at] = 16'h0;
		end
		phase = (fill_at == 0) ? P_CODE : P_BITMAP;
	endfunction

	function automatic void store_entry(input logic [15:0] delta);
		running_sum = running_sum - delta;
		words[fill_at] = running_sum;
		walk_bitmap();
	endfunction

	function automatic void emit_run(input logic [15:0] w, input int count);
		int need;
		word_run_t r;
		need = (bytes_out < unpacked_bytes) ? (int'(unpacked_bytes) - bytes_out + 1) / 2 : 0;
		if (need == 0)
			need = 1;
		r.final_word = 1'b0;
		if (count >= need) begin
			count = need;
			r.final_word = 1'b1;
		end
		last_word = w;
		bytes_out += 2 * count;
		phase = r.final_word ? P_DONE : P_CODE;
		r.word_value = w;
		r.repeat_count = 9'(count);
		expected_runs.push_back(r);
	endfunction

	function automatic void unpack_step(input logic [1:0] k, input logic [15:0] p);
		logic [7:0]  b;
		logic [15:0] sb, v, e;
		b = p[7:0];
		sb = {{8{b[7]}}, b};
		case (phase)
			P_BITMAP: if (k == wtru_pkg::KIND_BITMAP) begin
				bit_shift = p;
				bits_left = 16;
				walk_bitmap();
			end
			P_FIRST: if (k == wtru_pkg::KIND_DELTA) begin
				v = sb - first_bias;
				if (!v[15]) begin
					held_byte = v;
					phase = P_SECOND;
				end else begin
					store_entry(v);
				end
			end
			P_SECOND: if (k == wtru_pkg::KIND_DELTA)
				store_entry({held_byte[7:0], b} - second_bias);
			P_CODE: if (k == wtru_pkg::KIND_CODE) begin
				e = words[b ^ wtru_pkg::CODE_FLIP];
				if (e == wtru_pkg::ENTRY_PAIR) begin
					held_byte = {8'h0, b};
					phase = P_LOW;
				end else if (e == wtru_pkg::ENTRY_REPEAT) begin
					phase = P_COUNT;
				end else if (e == wtru_pkg::ENTRY_LITERAL) begin
					phase = P_LITHI;
				end else begin
					emit_run(e + word_offset, 1);
				end
			end
			P_LITHI: if (k == wtru_pkg::KIND_CODE) begin
				held_byte = {8'h0, b};
				phase = P_LOW;
			end
			P_LOW: if (k == wtru_pkg::KIND_CODE)
				emit_run({held_byte[7:0], b}, 1);
			P_COUNT: if (k == wtru_pkg::KIND_CODE)
				emit_run(last_word, (b == 8'h0) ? 256 : int'(b));
			default: ;
		endcase
	endfunction

	task automatic send_item(input logic [1:0] k, input logic [15:0] p);
		if (!quiet && $urandom_range(4) == 0) begin
			@(negedge clk) push <= 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		kind <= k;
		payload <= p;
		do @(posedge clk); while (full);
		unpack_step(k, p);
		items_sent++;
	endtask

	// Send a byte item with random upper payload bits.
	task automatic send_byte(input logic [1:0] k, input logic [7:0] b);
		send_item(k, {8'($urandom), b});
	endtask

	task automatic settle();
		@(negedge clk) push <= 1'b0;
		wait (expected_runs.size() == 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk) cfg_we <= 1'b0;
		case (idx)
			wtru_pkg::REG_FIRST_BIAS:  first_bias = value;
			wtru_pkg::REG_SECOND_BIAS: second_bias = value;
			wtru_pkg::REG_WORD_OFFSET: word_offset = value;
			default:                   unpacked_bytes = value;
		endcase
	endtask

	// Pick delta bytes that store the wanted entry; fall back to random bytes.
	task automatic send_delta_for(input logic [15:0] target);
		logic [15:0] d, v, two;
		logic [7:0]  b1, b2;
		bit          found;
		d = running_sum - target;
		found = 1'b0;
		b1 = 8'($urandom);
		b2 = 8'($urandom);
		for (int i = 0; i < 256 && !found; i++) begin
			v = {{8{i[7]}}, i[7:0]} - first_bias;
			two = d + second_bias;
			if (v[15] && v == d) begin
				b1 = i[7:0];
				found = 1'b1;
			end else if (!v[15] && two[15:8] == v[7:0]) begin
				b1 = i[7:0];
				b2 = two[7:0];
				found = 1'b1;
			end
		end
		send_byte(wtru_pkg::KIND_DELTA, b1);
		if (phase == P_SECOND)
			send_byte(wtru_pkg::KIND_DELTA, b2);
	endtask

	function automatic logic [15:0] pick_entry();
		case ($urandom_range(15))
			0, 1:    return wtru_pkg::ENTRY_REPEAT;
			2, 3:    return wtru_pkg::ENTRY_LITERAL;
			4:       return wtru_pkg::ENTRY_PAIR;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_table_build();
		logic [15:0] bitmap;
		int          n;
		n = 0;
		while (phase inside {P_BITMAP, P_FIRST, P_SECOND}) begin
			if ($urandom_range(9) == 0) begin
				// drop: wrong kind for this phase, or the unused kind
				send_item((phase == P_BITMAP) ? wtru_pkg::KIND_DELTA : wtru_pkg::KIND_CODE,
					16'($urandom));
				send_item(wtru_pkg::KIND_NONE, 16'($urandom));
			end else if (phase == P_BITMAP) begin
				case (n)
					4: begin
						write_reg(wtru_pkg::REG_FIRST_BIAS, 16'hFFFF);
						write_reg(wtru_pkg::REG_SECOND_BIAS, 16'hFFFF);
					end
					8: begin
						write_reg(wtru_pkg::REG_FIRST_BIAS, 16'h8000);
						write_reg(wtru_pkg::REG_SECOND_BIAS, 16'h7FFF);
					end
					12: begin
						write_reg(wtru_pkg::REG_FIRST_BIAS, 16'($urandom));
						write_reg(wtru_pkg::REG_SECOND_BIAS, 16'($urandom));
					end
					14: begin
						write_reg(wtru_pkg::REG_FIRST_BIAS, 16'h0000);
						write_reg(wtru_pkg::REG_SECOND_BIAS, 16'h0000);
					end
					default: ;
				endcase
				bitmap = (n == 0) ? 16'hFFFF : (n == 1) ? 16'h0000 : (n == 2) ? 16'h8001 :
					16'($urandom);
				send_item(wtru_pkg::KIND_BITMAP, bitmap);
				n++;
			end else begin
				send_delta_for(pick_entry());
			end
		end
	endtask

	// Send one code with its follow-on bytes.
	task automatic send_code(input logic [7:0] code, input bit long_runs);
		send_byte(wtru_pkg::KIND_CODE, code);
		case (phase)
			P_LOW:   send_byte(wtru_pkg::KIND_CODE, 8'($urandom));
			P_LITHI: begin
				send_byte(wtru_pkg::KIND_CODE, 8'($urandom));
				send_byte(wtru_pkg::KIND_CODE, 8'($urandom));
			end
			P_COUNT: send_byte(wtru_pkg::KIND_CODE,
				long_runs ? 8'($urandom) : 8'($urandom_range(1, 6)));
			default: ;
		endcase
	endtask

	task automatic test_code_directed();
		int idx;
		write_reg(wtru_pkg::REG_UNPACKED, 16'hFFFF);
		write_reg(wtru_pkg::REG_WORD_OFFSET, 16'hFFFF);
		// send one repeat code, then every pair and literal code up to the item limit
		foreach (words[i]) begin
			if (words[i] == wtru_pkg::ENTRY_REPEAT) begin
				send_code(8'(i) ^ wtru_pkg::CODE_FLIP, 1'b0);
				break;
			end
		end
		foreach (words[i]) begin
			if (words[i] == wtru_pkg::ENTRY_PAIR || words[i] == wtru_pkg::ENTRY_LITERAL)
				send_code(8'(i) ^ wtru_pkg::CODE_FLIP, 1'b0);
			if (items_sent > 25 + 400)
				break;
		end
		idx = $urandom_range(255);
		send_code(8'(idx), 1'b0);
		send_item(wtru_pkg::KIND_BITMAP, 16'($urandom));
		send_item(wtru_pkg::KIND_DELTA, 16'($urandom));
	endtask

	task automatic test_code_random();
		int burst;
		burst = 0;
		while (items_sent < 1630 && bytes_out < 60000 && phase != P_DONE) begin
			if (burst == 250) begin
				write_reg(wtru_pkg::REG_WORD_OFFSET,
					($urandom_range(1)) ? 16'h0000 : 16'($urandom));
				burst = 0;
			end
			if ($urandom_range(15) == 0)
				send_item(2'($urandom_range(0, 3)) & ~wtru_pkg::KIND_CODE, 16'($urandom));
			else
				send_code(8'($urandom), $urandom_range(19) == 0);
			burst++;
		end
	endtask

	task automatic test_final();
		quiet = 1'b1;
		if (phase != P_DONE) begin
			// odd remainder rounds up to whole words
			write_reg(wtru_pkg::REG_UNPACKED, 16'(bytes_out + 3));
			while (phase != P_DONE)
				send_code(8'($urandom), 1'b1);
		end
		repeat (8) send_item(2'($urandom), 16'($urandom));
	endtask

	initial begin
		foreach (words[i])
			words[i] = 16'h0;
		bit_shift = '0;
		running_sum = '0;
		held_byte = '0;
		last_word = '0;
		bits_left = 0;
		fill_at = wtru_pkg::TableEntries;
		bytes_out = 0;
		phase = P_BITMAP;
		first_bias = '0;
		second_bias = '0;
		word_offset = '0;
		unpacked_bytes = '0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_table_build();
		test_code_directed();
		test_code_random();
		test_final();
		@(negedge clk) push <= 1'b0;
		wait (expected_runs.size() == 0);
		repeat (SettleCycles) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
